// ----- rtl/core/pf_pkg.sv -----
// ----------------------------------------------------------------------------
// Playfair cipher package
// Shared types, key square reset value, and index helpers for the cipher.
// ----------------------------------------------------------------------------
package pf_pkg;

  localparam int SQ_SIZE   = 5;
  localparam int LETTER_W  = 5;
  localparam int IDX_W     = 3;
  localparam int ROW_W     = SQ_SIZE * LETTER_W;
  localparam int DATA_W    = 16;
  localparam int CFG_IDX_W = 3;

  typedef logic [LETTER_W-1:0] letter_t;
  typedef logic [IDX_W-1:0] idx_t;
  typedef letter_t [SQ_SIZE-1:0] row_t;
  typedef row_t [SQ_SIZE-1:0] square_t;

  typedef struct packed {
    logic found;
    idx_t row;
    idx_t col;
  } pos_t;

  localparam logic MODE_ENCODE = 1'b0;
  localparam logic MODE_DECODE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_SQUARE_ROW_0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SQUARE_ROW_1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SQUARE_ROW_2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SQUARE_ROW_3 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SQUARE_ROW_4 = 3'd4;

  localparam idx_t IDX_FIRST = 3'd0;
  localparam idx_t IDX_LAST  = 3'(SQ_SIZE - 1);

  localparam square_t SQUARE_RESET = {
    25'd26957459, 25'd19413418, 25'd7539777, 25'd13341224, 25'd6029679
  };

  // Moves one place forward when encoding and one place back when decoding,
  // wrapping around the row or column.
  function automatic idx_t step_idx(input idx_t idx, input logic mode);
    idx_t result;
    if (mode == MODE_DECODE) begin
      result = (idx == IDX_FIRST) ? IDX_LAST : idx - 3'd1;
    end else begin
      result = (idx == IDX_LAST) ? IDX_FIRST : idx + 3'd1;
    end
    return result;
  endfunction

endpackage

// ----- rtl/core/pf_keysq.sv -----
// ----------------------------------------------------------------------------
// Playfair key square registers
// Holds the five row registers and takes writes from the configuration port.
// ----------------------------------------------------------------------------
module pf_keysq (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          wr_en,
  input  logic [pf_pkg::CFG_IDX_W-1:0]  wr_index,
  input  logic [pf_pkg::ROW_W-1:0]      wr_data,
  output pf_pkg::square_t               square
);
  import pf_pkg::*;

  square_t rows;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows <= SQUARE_RESET;
    end else if (wr_en) begin
      case (wr_index)
        CFG_SQUARE_ROW_0: rows[0] <= wr_data;
        CFG_SQUARE_ROW_1: rows[1] <= wr_data;
        CFG_SQUARE_ROW_2: rows[2] <= wr_data;
        CFG_SQUARE_ROW_3: rows[3] <= wr_data;
        CFG_SQUARE_ROW_4: rows[4] <= wr_data;
        default: ;
      endcase
    end
  end

  assign square = rows;

endmodule

// ----- rtl/core/pf_locate.sv -----
// ----------------------------------------------------------------------------
// Playfair letter locator
// Compares a letter against all cells and returns the first match in raster
// order.
// ----------------------------------------------------------------------------
module pf_locate (
  input  pf_pkg::square_t square,
  input  pf_pkg::letter_t letter,
  output pf_pkg::pos_t    pos
);
  import pf_pkg::*;

  always_comb begin
    pos = '0;
    // Scanning backward lets the earliest raster match win.
    for (int r = SQ_SIZE - 1; r >= 0; r--) begin
      for (int c = SQ_SIZE - 1; c >= 0; c--) begin
        if (square[r][c] == letter) begin
          pos.found = 1'b1;
          pos.row   = IDX_W'(r);
          pos.col   = IDX_W'(c);
        end
      end
    end
  end

endmodule

// ----- rtl/core/pf_subst.sv -----
// ----------------------------------------------------------------------------
// Playfair pair substitution
// Locates both letters and applies the row, column, or rectangle rule.
// ----------------------------------------------------------------------------
module pf_subst (
  input  pf_pkg::square_t square,
  input  logic            mode,
  input  pf_pkg::letter_t first_letter,
  input  pf_pkg::letter_t second_letter,
  output pf_pkg::letter_t first_out,
  output pf_pkg::letter_t second_out,
  output logic            letter_missing
);
  import pf_pkg::*;

  pos_t pos_a;
  pos_t pos_b;
  idx_t row_a;
  idx_t col_a;
  idx_t row_b;
  idx_t col_b;

  pf_locate u_locate_a (
    .square (square),
    .letter (first_letter),
    .pos    (pos_a)
  );

  pf_locate u_locate_b (
    .square (square),
    .letter (second_letter),
    .pos    (pos_b)
  );

  always_comb begin
    row_a = pos_a.row;
    col_a = pos_b.col;
    row_b = pos_b.row;
    col_b = pos_a.col;
    if (pos_a.row == pos_b.row) begin
      col_a = step_idx(pos_a.col, mode);
      col_b = step_idx(pos_b.col, mode);
    end else if (pos_a.col == pos_b.col) begin
      row_a = step_idx(pos_a.row, mode);
      row_b = step_idx(pos_b.row, mode);
      col_a = pos_a.col;
      col_b = pos_b.col;
    end
  end

  assign letter_missing = !(pos_a.found && pos_b.found);
  assign first_out      = letter_missing ? '0 : square[row_a][col_a];
  assign second_out     = letter_missing ? '0 : square[row_b][col_b];

endmodule

// ----- rtl/core/playfair_digraph_cipher.sv -----
// ----------------------------------------------------------------------------
// Playfair digraph cipher
// Encodes or decodes one letter pair per transfer over a configurable 5x5
// key square.
// ----------------------------------------------------------------------------
// An accepted pair is held in the input register, then its result in the result register.
// Throughput: one pair per cycle; the input register and the result register
// form a two-stage pipeline that advances whenever the result register is
// empty or its result is taken.
// Reset: clears both pipeline stages and loads the SQUARE_RESET key square.
// ----------------------------------------------------------------------------
module playfair_digraph_cipher (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [4:0] first_letter, [9:5] second_letter, [15:10] zero
  input  logic [pf_pkg::DATA_W-1:0]     s_axis_tdata,
  // [0] mode
  input  logic                          s_axis_tuser,
  input  logic                          s_axis_tlast,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [4:0] first_out, [9:5] second_out, [15:10] zero
  output logic [pf_pkg::DATA_W-1:0]     m_axis_tdata,
  // [0] letter_missing
  output logic                          m_axis_tuser,
  output logic                          m_axis_tlast,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [pf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pf_pkg::ROW_W-1:0]      cfg_data
);
  import pf_pkg::*;

  square_t square;
  logic    advance_out;

  logic    stage_valid;
  logic    stage_mode;
  logic    stage_last;
  letter_t stage_first;
  letter_t stage_second;

  letter_t calc_first;
  letter_t calc_second;
  logic    calc_missing;

  logic    out_valid;
  letter_t out_first;
  letter_t out_second;
  logic    out_missing;
  logic    out_last;

  assign cfg_ready = 1'b1;

  pf_keysq u_keysq (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .square   (square)
  );

  pf_subst u_subst (
    .square         (square),
    .mode           (stage_mode),
    .first_letter   (stage_first),
    .second_letter  (stage_second),
    .first_out      (calc_first),
    .second_out     (calc_second),
    .letter_missing (calc_missing)
  );

  assign advance_out   = !out_valid || m_axis_tready;
  assign s_axis_tready = !stage_valid || advance_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        stage_valid <= s_axis_tvalid;
      end
      if (advance_out) begin
        out_valid <= stage_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      stage_mode   <= s_axis_tuser;
      stage_last   <= s_axis_tlast;
      stage_first  <= s_axis_tdata[LETTER_W-1:0];
      stage_second <= s_axis_tdata[2*LETTER_W-1:LETTER_W];
    end
    if (advance_out && stage_valid) begin
      out_first   <= calc_first;
      out_second  <= calc_second;
      out_missing <= calc_missing;
      out_last    <= stage_last;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {(DATA_W - 2*LETTER_W)'(0), out_second, out_first};
  assign m_axis_tuser  = out_missing;
  assign m_axis_tlast  = out_last;

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    stage_valid && m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input taken while both stages are full and stalled");

  a_missing_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[2*LETTER_W-1:0] == '0)
    else $error("missing letter result carries nonzero letters");

  a_input_enters_stage: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> stage_valid)
    else $error("accepted pair did not enter the input stage");

  a_stage_moves_out: assert property (@(posedge clk) disable iff (rst)
    stage_valid && advance_out |=> m_axis_tvalid)
    else $error("staged pair did not reach the result register");

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Playfair digraph cipher regression
// Sends letter pairs through the cipher under the reset key square, under
// degenerate squares and under many random squares. Each transfer is
// predicted from a local copy of the square, and each result transfer is
// compared with the oldest prediction. Both stream sides idle at random in most
// tests; the steady stream test runs without gaps or stalls.
module tb_top;
  import pf_pkg::*;

  typedef logic [ROW_W-1:0] key_row_t;

  typedef struct {
    letter_t first;
    letter_t second;
    logic    missing;
    logic    last;
  } pair_result_t;

  localparam logic [CFG_IDX_W-1:0] ROW_INDEX [SQ_SIZE] = '{
    CFG_SQUARE_ROW_0, CFG_SQUARE_ROW_1, CFG_SQUARE_ROW_2, CFG_SQUARE_ROW_3,
    CFG_SQUARE_ROW_4
  };

  logic                 clk;
  logic                 rst;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [DATA_W-1:0]    s_axis_tdata;
  logic                 s_axis_tuser;
  logic                 s_axis_tlast;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [DATA_W-1:0]    m_axis_tdata;
  logic                 m_axis_tuser;
  logic                 m_axis_tlast;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [ROW_W-1:0]     cfg_data;

  key_row_t     key_rows [SQ_SIZE];
  key_row_t     pending_rows [SQ_SIZE];
  pair_result_t expected_pairs [$];
  int           mismatches;
  bit           tx_gaps_on;
  bit           rx_stalls_on;
  int           rx_stall_left;

  playfair_digraph_cipher u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
  end

  always #10 clk = ~clk;

  initial begin
    #5_000_000;
    $display("playfair_digraph_cipher regression: fail");
    $finish;
  end

  function automatic letter_t square_cell(input int row, input int col);
    return key_rows[row][LETTER_W*col +: LETTER_W];
  endfunction

  function automatic void find_letter(input letter_t letter, output bit found,
                                      output int row, output int col);
    found = 1'b0;
    row = 0;
    col = 0;
    for (int r = SQ_SIZE - 1; r >= 0; r--) begin
      for (int c = SQ_SIZE - 1; c >= 0; c--) begin
        if (square_cell(r, c) == letter) begin
          found = 1'b1;
          row = r;
          col = c;
        end
      end
    end
  endfunction

  function automatic pair_result_t cipher_pair(input logic mode, input letter_t a,
                                               input letter_t b, input logic last);
    pair_result_t res;
    bit           found_a;
    bit           found_b;
    int           ra;
    int           ca;
    int           rb;
    int           cb;
    int           step;
    res.first = '0;
    res.second = '0;
    res.last = last;
    find_letter(a, found_a, ra, ca);
    find_letter(b, found_b, rb, cb);
    res.missing = !(found_a && found_b);
    step = (mode == MODE_DECODE) ? SQ_SIZE - 1 : 1;
    if (!res.missing) begin
      if (ra == rb) begin
        res.first = square_cell(ra, (ca + step) % SQ_SIZE);
        res.second = square_cell(rb, (cb + step) % SQ_SIZE);
      end else if (ca == cb) begin
        res.first = square_cell((ra + step) % SQ_SIZE, ca);
        res.second = square_cell((rb + step) % SQ_SIZE, cb);
      end else begin
        res.first = square_cell(ra, cb);
        res.second = square_cell(rb, ca);
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin
    if (rx_stall_left != 0) begin
      rx_stall_left = rx_stall_left - 1;
    end else if (rx_stalls_on && $urandom_range(0, 5) == 0) begin
      rx_stall_left = $urandom_range(1, 3);
    end
    m_axis_tready <= (rx_stall_left == 0);
  end

  task automatic check_field(input string name, input int expv, input int act);
    if (expv != act) begin
      $error("%s: expected %0d, actual %0d", name, expv, act);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    pair_result_t exp_pair;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_pairs.size() == 0) begin
        $error("result transfer with no pair outstanding");
        mismatches++;
      end else begin
        exp_pair = expected_pairs.pop_front();
        check_field("first_out", exp_pair.first, m_axis_tdata[LETTER_W-1:0]);
        check_field("second_out", exp_pair.second, m_axis_tdata[2*LETTER_W-1:LETTER_W]);
        check_field("tdata_pad", 0, m_axis_tdata[DATA_W-1:2*LETTER_W]);
        check_field("letter_missing", exp_pair.missing, m_axis_tuser);
        check_field("last_pair_out", exp_pair.last, m_axis_tlast);
      end
    end
  end

  task automatic send_pair(input logic mode, input letter_t a, input letter_t b,
                           input logic last);
    s_axis_tdata <= {{(DATA_W - 2*LETTER_W){1'b0}}, b, a};
    s_axis_tuser <= mode;
    s_axis_tlast <= last;
    s_axis_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    expected_pairs.insert(expected_pairs.size(), cipher_pair(mode, a, b, last));
    if (tx_gaps_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  task automatic send_random_pair();
    letter_t a;
    letter_t b;
    int      ra;
    int      ca;
    int      rb;
    int      cb;
    int      pick;
    pick = $urandom_range(0, 19);
    ra = $urandom_range(0, SQ_SIZE - 1);
    ca = $urandom_range(0, SQ_SIZE - 1);
    rb = $urandom_range(0, SQ_SIZE - 1);
    cb = $urandom_range(0, SQ_SIZE - 1);
    case ($urandom_range(0, 2))
      0: rb = ra;
      1: cb = ca;
      default: ;
    endcase
    a = square_cell(ra, ca);
    b = square_cell(rb, cb);
    if (pick < 2) begin
      a = letter_t'($urandom_range(0, 31));
      b = letter_t'($urandom_range(0, 31));
    end else if (pick == 2) begin
      b = letter_t'($urandom_range(0, 31));
    end else if (pick == 3) begin
      a = letter_t'($urandom_range(0, 31));
    end
    send_pair(1'($urandom_range(0, 1)), a, b, 1'($urandom_range(0, 1)));
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (expected_pairs.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic program_square();
    for (int r = 0; r < SQ_SIZE; r++) begin
      cfg_index <= ROW_INDEX[r];
      cfg_data <= pending_rows[r];
      cfg_valid <= 1'b1;
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      key_rows[r] = pending_rows[r];
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic test_reset_square();
    send_pair(MODE_ENCODE, 5'd15, 5'd5, 1'b0);
    send_pair(MODE_DECODE, 5'd15, 5'd5, 1'b1);
    send_pair(MODE_ENCODE, 5'd0, 5'd21, 1'b0);
    send_pair(MODE_DECODE, 5'd0, 5'd21, 1'b0);
    send_pair(MODE_ENCODE, 5'd7, 5'd8, 1'b1);
    send_pair(MODE_DECODE, 5'd7, 5'd8, 1'b0);
    send_pair(MODE_ENCODE, 5'd4, 5'd4, 1'b0);
    send_pair(MODE_DECODE, 5'd25, 5'd25, 1'b1);
    send_pair(MODE_ENCODE, 5'd9, 5'd0, 1'b0);
    send_pair(MODE_DECODE, 5'd1, 5'd9, 1'b0);
    send_pair(MODE_ENCODE, 5'd9, 5'd9, 1'b1);
    send_pair(MODE_ENCODE, 5'd31, 5'd0, 1'b0);
    send_pair(MODE_DECODE, 5'd26, 5'd25, 1'b0);
    send_pair(MODE_ENCODE, 5'd0, 5'd31, 1'b1);
    send_pair(MODE_ENCODE, 5'd0, 5'd25, 1'b0);
    send_pair(MODE_DECODE, 5'd0, 5'd25, 1'b1);
    send_pair(MODE_DECODE, 5'd19, 5'd25, 1'b0);
    settle();
  endtask

  task automatic test_degenerate_squares();
    for (int r = 0; r < SQ_SIZE; r++) pending_rows[r] = '0;
    program_square();
    send_pair(MODE_ENCODE, 5'd0, 5'd0, 1'b0);
    send_pair(MODE_DECODE, 5'd0, 5'd0, 1'b1);
    send_pair(MODE_ENCODE, 5'd5, 5'd0, 1'b0);
    settle();
    for (int r = 0; r < SQ_SIZE; r++) pending_rows[r] = '1;
    program_square();
    send_pair(MODE_ENCODE, 5'd31, 5'd31, 1'b1);
    send_pair(MODE_DECODE, 5'd31, 5'd31, 1'b0);
    send_pair(MODE_ENCODE, 5'd0, 5'd31, 1'b0);
    settle();
    // Repeated letters and codes above Z: the first hit in raster order wins.
    for (int r = 0; r < SQ_SIZE; r++) begin
      for (int c = 0; c < SQ_SIZE; c++) begin
        pending_rows[r][LETTER_W*c +: LETTER_W] =
          letter_t'((r + c) % 3 + ((c == 4) ? 28 : 0));
      end
    end
    program_square();
    send_pair(MODE_ENCODE, 5'd1, 5'd2, 1'b0);
    send_pair(MODE_DECODE, 5'd2, 5'd30, 1'b1);
    send_pair(MODE_ENCODE, 5'd28, 5'd0, 1'b0);
    settle();
  endtask

  task automatic test_random_squares();
    letter_t pool [26];
    letter_t swap_letter;
    int      j;
    for (int phase = 0; phase < 6; phase++) begin
      if (phase == 2 || phase == 5) begin
        for (int r = 0; r < SQ_SIZE; r++) pending_rows[r] = key_row_t'($urandom);
      end else begin
        for (int i = 0; i < 26; i++) pool[i] = letter_t'(i);
        for (int i = 25; i > 0; i--) begin
          j = $urandom_range(0, i);
          swap_letter = pool[i];
          pool[i] = pool[j];
          pool[j] = swap_letter;
        end
        for (int r = 0; r < SQ_SIZE; r++) begin
          for (int c = 0; c < SQ_SIZE; c++) begin
            pending_rows[r][LETTER_W*c +: LETTER_W] = pool[SQ_SIZE*r + c];
          end
        end
      end
      program_square();
      tx_gaps_on = (phase != 1);
      rx_stalls_on = (phase != 3);
      repeat (250) send_random_pair();
      settle();
    end
  endtask

  task automatic test_steady_stream();
    for (int r = 0; r < SQ_SIZE; r++) pending_rows[r] = SQUARE_RESET[r];
    program_square();
    tx_gaps_on = 1'b0;
    rx_stalls_on = 1'b0;
    repeat (350) send_random_pair();
    settle();
  endtask

  initial begin
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = 1'b0;
    s_axis_tlast = 1'b0;
    m_axis_tready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    mismatches = 0;
    tx_gaps_on = 1'b1;
    rx_stalls_on = 1'b1;
    rx_stall_left = 0;
    for (int r = 0; r < SQ_SIZE; r++) key_rows[r] = SQUARE_RESET[r];
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_square();
    test_degenerate_squares();
    test_random_squares();
    test_steady_stream();
    if (mismatches == 0) begin
      $display("playfair_digraph_cipher regression: pass");
    end else begin
      $display("playfair_digraph_cipher regression: fail");
    end
    $finish;
  end

endmodule

// ----- playfair_digraph_cipher.f -----
rtl/core/pf_pkg.sv
rtl/core/pf_keysq.sv
rtl/core/pf_locate.sv
rtl/core/pf_subst.sv
rtl/core/playfair_digraph_cipher.sv
bench/tb_top.sv
